FILE: design/alignment_column_colour_unit_assert.svh
// Assertion macros used by the checker of the column color unit.
`ifndef ALIGNMENT_COLUMN_COLOUR_UNIT_ASSERT_SVH
`define ALIGNMENT_COLUMN_COLOUR_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define ACC_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define ACC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check of the state left by a reset cycle, in the cycle after reset is sampled low
`define ACC_CHECK_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/acc_pkg.sv
// Shared types, constants and lookup functions of the column color unit.
package acc_pkg;

    localparam int ROW_W     = 6;   // row index within a column
    localparam int CNT_W     = 7;   // row count register
    localparam int MODE_W    = 2;
    localparam int SUM_W     = 9;   // per-channel sum of fifths, wraps
    localparam int LEVEL_W   = 13;  // Q1.12 intensity, 4096 is 1.0
    localparam int NUM_W     = 13;  // scaled numerator before division
    localparam int FRAC_W    = 12;
    localparam int QUO_W     = NUM_W + FRAC_W;
    localparam int DEN_W     = 11;  // rows * 30
    localparam int STEP_W    = 5;
    localparam int DIST_W    = 5;   // distinct letter count, up to 26
    localparam int LETTERS   = 26;
    localparam int CHANNELS  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [STEP_W-1:0]  DIV_STEPS       = STEP_W'(QUO_W);
    localparam logic [LEVEL_W-1:0] LEVEL_ONE       = 13'd4096;
    localparam logic [DEN_W-1:0]   DEN_PER_ROW     = 11'd30;
    localparam logic [11:0]        SUM_SCALE       = 12'd6;
    localparam logic [DIST_W-1:0]  NO_LETTER_SPREAD = 5'd19;
    localparam logic [CNT_W-1:0]   ROW_COUNT_RESET = 7'd64;
    localparam logic [7:0]         SPACE_CHAR      = 8'h20;
    localparam logic [7:0]         CASE_MASK       = 8'hDF;
    localparam logic [7:0]         CHAR_A          = 8'h41;
    localparam logic [7:0]         CHAR_Z          = 8'h5A;

    // color modes
    localparam logic [MODE_W-1:0] MODE_INDIVIDUAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVERAGE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DARKEN     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LIGHTEN    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 1'd1;

    typedef logic [2:0]         t_fifth;
    typedef t_fifth [2:0]       t_tint;      // [0] red, [1] green, [2] blue
    typedef logic [LEVEL_W-1:0] t_level;
    typedef t_level [2:0]       t_rgb;
    typedef logic [NUM_W-1:0]   t_num;
    typedef t_num [2:0]         t_num_rgb;
    typedef logic [SUM_W-1:0]   t_sum;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } t_letter;

    // one finished column handed from front to back
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_rgb              rgb;
        logic [ROW_W-1:0]  last;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_col_req;

    // letter index of a byte, either case
    function automatic t_letter letter_of(input logic [7:0] b);
        logic [7:0] up;
        t_letter    res;
        up = b & CASE_MASK;
        res.hit = (up >= CHAR_A) && (up <= CHAR_Z);
        res.idx = 5'(up - CHAR_A);
        return res;
    endfunction

    // color table in fifths, written blue green red
    function automatic t_tint tint_of(input logic [4:0] idx);
        t_tint t;
        case (idx)
            5'd0:    t = {3'd0, 3'd5, 3'd4};
            5'd2:    t = {3'd0, 3'd5, 3'd5};
            5'd3:    t = {3'd0, 3'd0, 3'd5};
            5'd4:    t = {3'd2, 3'd0, 3'd5};
            5'd5:    t = {3'd2, 3'd5, 3'd0};
            5'd6:    t = {3'd0, 3'd3, 3'd5};
            5'd7:    t = {3'd5, 3'd2, 3'd0};
            5'd8:    t = {3'd0, 3'd5, 3'd2};
            5'd10:   t = {3'd5, 3'd0, 3'd2};
            5'd11:   t = {3'd0, 3'd5, 3'd1};
            5'd12:   t = {3'd0, 3'd5, 3'd0};
            5'd13:   t = {3'd5, 3'd0, 3'd4};
            5'd15:   t = {3'd0, 3'd4, 3'd5};
            5'd16:   t = {3'd4, 3'd0, 3'd5};
            5'd17:   t = {3'd5, 3'd0, 3'd0};
            5'd18:   t = {3'd0, 3'd1, 3'd5};
            5'd19:   t = {3'd0, 3'd2, 3'd5};
            5'd21:   t = {3'd0, 3'd5, 3'd3};
            5'd22:   t = {3'd5, 3'd4, 3'd0};
            5'd23:   t = {3'd5, 3'd5, 3'd5};
            5'd24:   t = {3'd4, 3'd5, 3'd0};
            default: t = '0;   // B J O U Z and unused codes are black
        endcase
        return t;
    endfunction

    // fifths to Q1.12, truncated
    function automatic t_level fifth_to_level(input t_fifth f);
        t_level l;
        case (f)
            3'd1:    l = 13'd819;
            3'd2:    l = 13'd1638;
            3'd3:    l = 13'd2457;
            3'd4:    l = 13'd3276;
            3'd5:    l = 13'd4096;
            default: l = '0;
        endcase
        return l;
    endfunction

endpackage

FILE: design/alignment_column_colour_unit.sv
// Top level of the alignment column color unit.
//
//  channel   direction  handshake            payload
//  residue   in         i_push / o_full      i_residue
//  result    out        o_empty / i_pop      o_residue_out, o_red, o_green, o_blue,
//                                            o_column_end
//  config    in         i_cfg_valid /        i_cfg_index, i_cfg_data
//                       o_cfg_ready
//
// The front end takes one residue per cycle while o_full is low. After the last
// row of a column it scales, runs the bit-serial divider and hands the column to
// the back end; o_full stays high until then. The back end reads each row from
// RAM into an output register, not while a read is pending or a result waits.
// The buffer has two banks, so the next column fills while the previous one drains;
// o_full is also high while both banks hold unsent columns. Reset is synchronous.
module alignment_column_colour_unit
    import acc_pkg::*;
#(
    parameter int MAX_ROWS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [7:0]           i_residue,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_residue_out,
    output logic [LEVEL_W-1:0]   o_red,
    output logic [LEVEL_W-1:0]   o_green,
    output logic [LEVEL_W-1:0]   o_blue,
    output logic                 o_column_end,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    localparam int IW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RAM_DEPTH = 2 ** (IW + 1);

    logic [MODE_W-1:0] r_colour_mode;
    logic [CNT_W-1:0]  r_row_count;

    t_col_req    col;
    logic        q_full;
    logic        ram_we;
    logic [IW:0] ram_waddr;
    logic [7:0]  ram_wdata;
    logic        ram_re;
    logic [IW:0] ram_raddr;
    logic [7:0]  ram_rdata;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_mode <= MODE_AVERAGE;
            r_row_count   <= ROW_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COLOUR_MODE: r_colour_mode <= i_cfg_data[MODE_W-1:0];
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data;
                default:         r_row_count   <= r_row_count;
            endcase
        end
    end

    acc_front #(
        .MAX_ROWS (MAX_ROWS),
        .IW       (IW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_residue   (i_residue),
        .o_full      (o_full),
        .i_mode      (r_colour_mode),
        .i_row_count (r_row_count),
        .i_q_full    (q_full),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_col       (col)
    );

    // two-bank row buffer
    acc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_row_buffer (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    acc_back #(
        .IW (IW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_col         (col),
        .o_q_full      (q_full),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_residue_out (o_residue_out),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_column_end  (o_column_end)
    );

endmodule

FILE: design/acc_ram.sv
// Generic simple dual-port RAM with registered read.
module acc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/acc_div.sv
// Three-lane restoring divider: level = min(num * 4096 / den, 4096), one bit per cycle.
module acc_div
    import acc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_num_rgb         i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output t_rgb             o_level
);

    logic [CHANNELS-1:0][QUO_W-1:0] r_quo, n_quo;
    logic [CHANNELS-1:0][DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0]               r_den;
    logic [STEP_W-1:0]              r_cnt;
    logic                           r_busy;
    logic                           r_done;

    // one quotient bit per lane
    always_comb begin
        logic [DEN_W:0] trial;
        logic           ge;
        for (int c = 0; c < CHANNELS; c++) begin
            trial    = {r_rem[c], r_quo[c][QUO_W-1]};
            ge       = (trial >= {1'b0, r_den});
            n_quo[c] = {r_quo[c][QUO_W-2:0], ge};
            n_rem[c] = ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int c = 0; c < CHANNELS; c++) begin
                r_quo[c] <= {i_num[c], {FRAC_W{1'b0}}};
                r_rem[c] <= '0;
            end
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    // saturate to 1.0
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            o_level[c] = (r_quo[c] > QUO_W'(LEVEL_ONE)) ? LEVEL_ONE
                                                         : r_quo[c][LEVEL_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

FILE: design/acc_front.sv
// Front end: takes residues, buffers them, sums colors and averages each column.
module acc_front
    import acc_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int IW       = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_residue,
    output logic              o_full,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [CNT_W-1:0]  i_row_count,
    input  logic              i_q_full,
    output logic              o_ram_we,
    output logic [IW:0]       o_ram_waddr,
    output logic [7:0]        o_ram_wdata,
    output t_col_req          o_col
);

    localparam logic [1:0] S_TAKE  = 2'd0;
    localparam logic [1:0] S_SCALE = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;

    logic [1:0]                   r_state;
    logic [ROW_W-1:0]             r_row;
    logic                         r_bank;
    logic [CHANNELS-1:0][SUM_W-1:0] r_sum, n_sum;
    logic [LETTERS-1:0]           r_seen, n_seen;
    logic [DIST_W-1:0]            r_distinct, n_distinct;
    logic [MODE_W-1:0]            r_mode;
    logic [CNT_W-1:0]             r_n;

    logic             accept;
    logic             col_end;
    logic [CNT_W-1:0] n_used;
    t_letter          let_in;
    t_tint            tint_in;
    logic             lighten_space;
    logic [DIST_W-1:0] spread;
    logic [11:0]      adj;
    t_num_rgb         num;
    logic [DEN_W-1:0] den;
    logic             div_start;
    logic             div_done;
    t_rgb             div_level;

    // effective row count
    always_comb begin
        if (i_row_count == '0) begin
            n_used = CNT_W'(1);
        end else if (i_row_count > CNT_W'(MAX_ROWS)) begin
            n_used = CNT_W'(MAX_ROWS);
        end else begin
            n_used = i_row_count;
        end
    end

    assign o_full  = (r_state != S_TAKE) || i_q_full;
    assign accept  = i_push && !o_full;
    assign col_end = (CNT_W'(r_row) + 1'b1) >= n_used;

    // residue classification and running sums
    assign let_in        = letter_of(i_residue);
    assign tint_in       = tint_of(let_in.idx);
    assign lighten_space = (i_mode == MODE_LIGHTEN) && (i_residue == SPACE_CHAR);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (lighten_space) begin
                n_sum[c] = r_sum[c] + SUM_W'(5);
            end else if (let_in.hit) begin
                n_sum[c] = r_sum[c] + SUM_W'(tint_in[c]);
            end else begin
                n_sum[c] = r_sum[c];
            end
        end
        n_seen     = r_seen;
        n_distinct = r_distinct;
        if (let_in.hit) begin
            n_seen[let_in.idx] = 1'b1;
            if (!r_seen[let_in.idx]) begin
                n_distinct = r_distinct + 1'b1;
            end
        end
    end

    // buffer write
    assign o_ram_we    = accept;
    assign o_ram_waddr = {r_bank, r_row[IW-1:0]};
    assign o_ram_wdata = i_residue;

    // scale numerators: sum*6 -/+ spread*rows
    assign spread = (r_distinct == '0) ? NO_LETTER_SPREAD : r_distinct - 1'b1;
    assign adj    = {7'b0, spread} * {5'b0, r_n};
    assign den    = DEN_W'({4'b0, r_n} * DEN_PER_ROW);

    always_comb begin
        logic [11:0]        scaled;
        logic signed [13:0] diff;
        for (int c = 0; c < CHANNELS; c++) begin
            scaled = {3'b0, r_sum[c]} * SUM_SCALE;
            unique case (r_mode)
                MODE_DARKEN:  diff = $signed({2'b0, scaled}) - $signed({2'b0, adj});
                MODE_LIGHTEN: diff = $signed({2'b0, scaled}) + $signed({2'b0, adj});
                default:      diff = $signed({2'b0, scaled});
            endcase
            num[c] = (diff <= 14'sd0) ? '0 : diff[NUM_W-1:0];
        end
    end

    assign div_start = (r_state == S_SCALE);

    acc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_level (div_level)
    );

    // column request to the back end
    always_comb begin
        o_col.valid     = (r_state == S_DIV) && div_done;
        o_col.desc.mode = r_mode;
        o_col.desc.rgb  = div_level;
        o_col.desc.last = r_row;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_TAKE;
            r_row      <= '0;
            r_bank     <= 1'b0;
            r_sum      <= '0;
            r_seen     <= '0;
            r_distinct <= '0;
        end else begin
            unique case (r_state)
                S_TAKE: begin
                    if (accept) begin
                        r_sum      <= n_sum;
                        r_seen     <= n_seen;
                        r_distinct <= n_distinct;
                        if (col_end) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end
                end
                S_SCALE: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state    <= S_TAKE;
                        r_row      <= '0;
                        r_bank     <= ~r_bank;
                        r_sum      <= '0;
                        r_seen     <= '0;
                        r_distinct <= '0;
                    end
                end
                default: begin
                    r_state <= S_TAKE;
                end
            endcase
        end
    end

    // mode and row count as seen at column end
    always_ff @(posedge i_clk) begin
        if (accept && col_end) begin
            r_mode <= i_mode;
            r_n    <= n_used;
        end
    end

endmodule

FILE: design/acc_back.sv
// Back end: column queue, buffer read-out and output register.
module acc_back
    import acc_pkg::*;
#(
    parameter int IW = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_col_req     i_col,
    output logic         o_q_full,
    output logic         o_ram_re,
    output logic [IW:0]  o_ram_raddr,
    input  logic [7:0]   i_ram_rdata,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [7:0]   o_residue_out,
    output t_level       o_red,
    output t_level       o_green,
    output t_level       o_blue,
    output logic         o_column_end
);

    t_desc              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_q_cnt;
    logic [ROW_W-1:0]   r_row;
    logic               r_bank;
    logic               r_rd_pend;
    logic [MODE_W-1:0]  r_p_mode;
    t_rgb               r_p_rgb;
    logic               r_p_end;
    logic               r_out_valid;
    logic [7:0]         r_out_res;
    t_rgb               r_out_rgb;
    logic               r_out_end;

    t_desc   head;
    logic    pop_acc;
    logic    issue;
    logic    issue_last;
    logic    pop_q;
    t_letter let_rd;
    t_tint   tint_rd;
    t_rgb    rgb_rd;

    assign head       = r_q[r_rd_ptr];
    assign o_q_full   = (r_q_cnt == QCNT_W'(QUEUE_DEPTH));
    assign pop_acc    = i_pop && r_out_valid;
    assign issue      = (r_q_cnt != '0) && !r_rd_pend && (!r_out_valid || pop_acc);
    assign issue_last = (r_row == head.last);
    assign pop_q      = issue && issue_last;

    assign o_ram_re    = issue;
    assign o_ram_raddr = {r_bank, r_row[IW-1:0]};

    // color of the row just read
    assign let_rd  = letter_of(i_ram_rdata);
    assign tint_rd = tint_of(let_rd.idx);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_p_mode != MODE_INDIVIDUAL) begin
                rgb_rd[c] = r_p_rgb[c];
            end else if (let_rd.hit) begin
                rgb_rd[c] = fifth_to_level(tint_rd[c]);
            end else begin
                rgb_rd[c] = '0;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_q_cnt     <= '0;
            r_row       <= '0;
            r_bank      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_col.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            case ({i_col.valid, pop_q})
                2'b10:   r_q_cnt <= r_q_cnt + 1'b1;
                2'b01:   r_q_cnt <= r_q_cnt - 1'b1;
                default: r_q_cnt <= r_q_cnt;
            endcase
            if (issue) begin
                if (issue_last) begin
                    r_row    <= '0;
                    r_bank   <= ~r_bank;
                    r_rd_ptr <= r_rd_ptr + 1'b1;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
            r_rd_pend <= issue;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (pop_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_col.valid) begin
            r_q[r_wr_ptr] <= i_col.desc;
        end
        if (issue) begin
            r_p_mode <= head.mode;
            r_p_rgb  <= head.rgb;
            r_p_end  <= issue_last;
        end
        if (r_rd_pend) begin
            r_out_res <= i_ram_rdata;
            r_out_rgb <= rgb_rd;
            r_out_end <= r_p_end;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_residue_out = r_out_res;
    assign o_red         = r_out_rgb[0];
    assign o_green       = r_out_rgb[1];
    assign o_blue        = r_out_rgb[2];
    assign o_column_end  = r_out_end;

endmodule

FILE: design/acc_checker.sv
// Port-level checker of the column color unit, bound to the top level.
`include "alignment_column_colour_unit_assert.svh"

module acc_checker
    import acc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_full,
    input logic               i_pop,
    input logic               o_empty,
    input logic [7:0]         o_residue_out,
    input logic [LEVEL_W-1:0] o_red,
    input logic [LEVEL_W-1:0] o_green,
    input logic [LEVEL_W-1:0] o_blue,
    input logic               o_column_end
);

    // reset leaves no result pending
    `ACC_CHECK_RESET(a_reset_empty, o_empty, "result pending after reset")

    // reset leaves the input side open
    `ACC_CHECK_RESET(a_reset_open, !o_full, "input blocked after reset")

    // an untaken result stays put
    `ACC_CHECK_NEXT(a_hold_result, !o_empty && !i_pop, !o_empty && $stable(o_residue_out) && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_column_end), "result changed while stalled")

    // shown levels never exceed 1.0
    `ACC_CHECK_NOW(a_level_range, !o_empty, o_red <= LEVEL_ONE && o_green <= LEVEL_ONE && o_blue <= LEVEL_ONE, "level above 1.0")

endmodule

bind alignment_column_colour_unit acc_checker u_acc_checker (.*);
